// ===== design/nearest_ray_circle_hit_assert.svh =====
// Assertion macros for the nearest ray/circle hit block.
// Used by nearest_ray_circle_hit.sv; expects aclk and aresetn in scope.
`ifndef NEAREST_RAY_CIRCLE_HIT_ASSERT_SVH
`define NEAREST_RAY_CIRCLE_HIT_ASSERT_SVH

// Same-cycle implication, checked only out of reset.
`define NRCH_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only out of reset.
`define NRCH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/nrch_pkg.sv =====
// Shared types and constants for the nearest ray/circle hit block.
// No dependencies; used by nearest_ray_circle_hit.sv.
package nrch_pkg;

    localparam int unsigned MAX_CIRCLES_DEF = 64;

    localparam int unsigned COORD_W  = 24;
    localparam int unsigned DIR_W    = 16;
    localparam int unsigned RAD_W    = 20;
    localparam int unsigned RANGE_W  = 23;
    localparam int unsigned IDX_W    = 6;
    localparam int unsigned DIFF_W   = COORD_W + 1;
    localparam int unsigned MUL_B_W  = RAD_W + 1;
    localparam int unsigned PROD_W   = DIFF_W + MUL_B_W;
    localparam int unsigned ACC_W    = 42;
    localparam int unsigned FRAC_SH  = 14;
    localparam int unsigned PROJ_W   = ACC_W - FRAC_SH;
    localparam int unsigned SURF_W   = PROJ_W + 1;
    localparam int unsigned BEST_W   = RANGE_W + 2;
    localparam int unsigned RADSQ_W  = 2 * RAD_W;
    localparam int unsigned ROOT_W   = RAD_W;
    localparam int unsigned REM_W    = ROOT_W + 2;
    localparam int unsigned SQRT_STEPS = ROOT_W;
    localparam int unsigned SQ_CNT_W = $clog2(SQRT_STEPS);
    localparam int unsigned STEP_W   = 3;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [RANGE_W-1:0] MAX_RANGE_RST = RANGE_W'(32000);
    localparam logic [0:0]         REG_MAX_RANGE = 1'b0;

    // Multiply schedule steps
    localparam logic [STEP_W-1:0] STEP_DX_FX  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_DY_FY  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_DX_FY  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_DY_FX  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_R_R    = 3'd4;
    localparam logic [STEP_W-1:0] STEP_PERP   = 3'd5;
    localparam logic [STEP_W-1:0] STEP_P_P    = 3'd6;
    localparam logic [STEP_W-1:0] STEP_RADSQ  = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SQRT,
        ST_SUB,
        ST_CMP,
        ST_FIN
    } nrch_state_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] ray_origin_x;
        logic signed [COORD_W-1:0] ray_origin_y;
        logic signed [DIR_W-1:0]   ray_dir_x;
        logic signed [DIR_W-1:0]   ray_dir_y;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic [RAD_W-1:0]          radius;
        logic                      eligible;
        logic                      last_item;
    } nrch_in_t;

    typedef struct packed {
        logic                      found;
        logic [IDX_W-1:0]          best_index;
        logic signed [COORD_W-1:0] best_distance;
    } nrch_out_t;

endpackage

// ===== design/nearest_ray_circle_hit.sv =====
// Nearest ray/circle hit over a batch of circle words; one shared multiplier and a
// bit-serial square root under one sequencer. Depends on nrch_pkg and the assert header.
// Eligible word: 8-step multiply schedule, 20-step root, then three closing steps
//   (SUB, CMP, FIN); a miss skips the root, an ineligible word goes straight to FIN.
// Throughput: one word at a time; the result word waits in its register for m_ready.
// Reset (aresetn low, synchronous): max_range back to 32000, batch state cleared.
`include "nearest_ray_circle_hit_assert.svh"

module nearest_ray_circle_hit #(
    parameter int unsigned MAX_CIRCLES = nrch_pkg::MAX_CIRCLES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input circle words
    input  logic                                s_valid,
    output logic                                s_ready,
    input  nrch_pkg::nrch_in_t                  s_data,
    // result words
    output logic                                m_valid,
    input  logic                                m_ready,
    output nrch_pkg::nrch_out_t                 m_data,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [nrch_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [nrch_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [nrch_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int unsigned CNT_W = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    nrch_pkg::nrch_state_t state_reg, state_next;
    logic [nrch_pkg::STEP_W-1:0]      step_reg, step_next;
    logic [nrch_pkg::SQ_CNT_W-1:0]    sq_cnt_reg, sq_cnt_next;
    logic [CNT_W-1:0]                 item_count_reg, item_count_next;
    logic signed [nrch_pkg::BEST_W-1:0] best_dist_reg, best_dist_next;
    logic [nrch_pkg::IDX_W-1:0]       best_idx_reg, best_idx_next;
    logic                             hit_seen_reg, hit_seen_next;
    logic                             m_valid_reg, m_valid_next;
    logic [nrch_pkg::RANGE_W-1:0]     max_range_reg;

    // ------------------------------------------------------------------
    // Datapath registers (no reset)
    // ------------------------------------------------------------------
    logic signed [nrch_pkg::DIFF_W-1:0]  dx_reg, dx_next;
    logic signed [nrch_pkg::DIFF_W-1:0]  dy_reg, dy_next;
    logic signed [nrch_pkg::DIR_W-1:0]   fx_reg, fx_next;
    logic signed [nrch_pkg::DIR_W-1:0]   fy_reg, fy_next;
    logic [nrch_pkg::RAD_W-1:0]          r_reg, r_next;
    logic                                last_reg, last_next;
    logic signed [nrch_pkg::PROD_W-1:0]  prod_reg, prod_next;
    logic signed [nrch_pkg::ACC_W-1:0]   proj_reg, proj_next;
    logic signed [nrch_pkg::ACC_W-1:0]   cross_reg, cross_next;
    logic [nrch_pkg::PROJ_W-1:0]         perp_reg, perp_next;
    logic [nrch_pkg::RADSQ_W-1:0]        rad_reg, rad_next;
    logic [nrch_pkg::REM_W-1:0]          rem_reg, rem_next;
    logic [nrch_pkg::ROOT_W-1:0]         root_reg, root_next;
    logic signed [nrch_pkg::SURF_W-1:0]  surf_reg, surf_next;
    nrch_pkg::nrch_out_t                 m_data_reg, m_data_next;

    // ------------------------------------------------------------------
    // Shared multiplier: operands picked by the schedule step
    // ------------------------------------------------------------------
    logic signed [nrch_pkg::DIFF_W-1:0]  mul_a;
    logic signed [nrch_pkg::MUL_B_W-1:0] mul_b;
    logic signed [nrch_pkg::PROD_W-1:0]  mul_p;

    always_comb begin
        case (step_reg)
            nrch_pkg::STEP_DX_FX: begin
                mul_a = dx_reg;
                mul_b = nrch_pkg::MUL_B_W'(fx_reg);
            end
            nrch_pkg::STEP_DY_FY: begin
                mul_a = dy_reg;
                mul_b = nrch_pkg::MUL_B_W'(fy_reg);
            end
            nrch_pkg::STEP_DX_FY: begin
                mul_a = dx_reg;
                mul_b = nrch_pkg::MUL_B_W'(fy_reg);
            end
            nrch_pkg::STEP_DY_FX: begin
                mul_a = dy_reg;
                mul_b = nrch_pkg::MUL_B_W'(fx_reg);
            end
            nrch_pkg::STEP_R_R: begin
                mul_a = nrch_pkg::DIFF_W'(r_reg);
                mul_b = nrch_pkg::MUL_B_W'(r_reg);
            end
            default: begin
                // perp is known to fit the radius width here
                mul_a = nrch_pkg::DIFF_W'(perp_reg[nrch_pkg::RAD_W-1:0]);
                mul_b = nrch_pkg::MUL_B_W'(perp_reg[nrch_pkg::RAD_W-1:0]);
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // ------------------------------------------------------------------
    // Helpers around the sequencer
    // ------------------------------------------------------------------
    logic [nrch_pkg::ACC_W-1:0]  cross_abs;
    logic [nrch_pkg::REM_W-1:0]  rem_sh;
    logic [nrch_pkg::REM_W-1:0]  trial;
    logic signed [nrch_pkg::SURF_W-1:0] r_s;
    logic signed [nrch_pkg::SURF_W-1:0] max_s;
    logic signed [nrch_pkg::SURF_W-1:0] best_s;
    logic                        cand_hit;
    logic [CNT_W:0]              cnt_inc;
    logic [CNT_W-1:0]            cnt_wrap;
    logic                        out_free;

    assign cross_abs = cross_reg[nrch_pkg::ACC_W-1] ? nrch_pkg::ACC_W'(-cross_reg)
                                                    : nrch_pkg::ACC_W'(cross_reg);

    // one root bit per cycle: bring down two radicand bits, try (root*4 + 1)
    assign rem_sh = {rem_reg[nrch_pkg::REM_W-3:0], rad_reg[nrch_pkg::RADSQ_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};

    assign r_s    = nrch_pkg::SURF_W'(r_reg);
    assign max_s  = nrch_pkg::SURF_W'(max_range_reg);
    assign best_s = nrch_pkg::SURF_W'(best_dist_reg);
    assign cand_hit = (surf_reg >= -r_s) && (surf_reg <= max_s) && (surf_reg < best_s);

    assign cnt_inc  = {1'b0, item_count_reg} + (CNT_W+1)'(1);
    assign cnt_wrap = (cnt_inc >= (CNT_W+1)'(MAX_CIRCLES)) ? '0 : cnt_inc[CNT_W-1:0];

    // output register can take a new word this cycle
    assign out_free = !m_valid_reg || m_ready;

    // ------------------------------------------------------------------
    // Sequencer: next state and datapath
    // ------------------------------------------------------------------
    always_comb begin
        state_next      = state_reg;
        step_next       = step_reg;
        sq_cnt_next     = sq_cnt_reg;
        item_count_next = item_count_reg;
        best_dist_next  = best_dist_reg;
        best_idx_next   = best_idx_reg;
        hit_seen_next   = hit_seen_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        fx_next         = fx_reg;
        fy_next         = fy_reg;
        r_next          = r_reg;
        last_next       = last_reg;
        prod_next       = prod_reg;
        proj_next       = proj_reg;
        cross_next      = cross_reg;
        perp_next       = perp_reg;
        rad_next        = rad_reg;
        rem_next        = rem_reg;
        root_next       = root_reg;
        surf_next       = surf_reg;
        m_data_next     = m_data_reg;

        case (state_reg)
            nrch_pkg::ST_IDLE: begin
                if (s_valid) begin
                    // capture the word and form center - origin
                    dx_next   = nrch_pkg::DIFF_W'(s_data.center_x)
                              - nrch_pkg::DIFF_W'(s_data.ray_origin_x);
                    dy_next   = nrch_pkg::DIFF_W'(s_data.center_y)
                              - nrch_pkg::DIFF_W'(s_data.ray_origin_y);
                    fx_next   = s_data.ray_dir_x;
                    fy_next   = s_data.ray_dir_y;
                    r_next    = s_data.radius;
                    last_next = s_data.last_item;
                    step_next = nrch_pkg::STEP_DX_FX;
                    state_next = s_data.eligible ? nrch_pkg::ST_MUL : nrch_pkg::ST_FIN;
                end
            end

            nrch_pkg::ST_MUL: begin
                step_next = step_reg + nrch_pkg::STEP_W'(1);
                case (step_reg)
                    nrch_pkg::STEP_DX_FX: begin
                        prod_next = mul_p;
                    end
                    nrch_pkg::STEP_DY_FY: begin
                        prod_next = mul_p;
                        proj_next = prod_reg[nrch_pkg::ACC_W-1:0];
                    end
                    nrch_pkg::STEP_DX_FY: begin
                        prod_next = mul_p;
                        proj_next = proj_reg + prod_reg[nrch_pkg::ACC_W-1:0];
                    end
                    nrch_pkg::STEP_DY_FX: begin
                        prod_next  = mul_p;
                        cross_next = prod_reg[nrch_pkg::ACC_W-1:0];
                    end
                    nrch_pkg::STEP_R_R: begin
                        prod_next  = mul_p;
                        cross_next = cross_reg - prod_reg[nrch_pkg::ACC_W-1:0];
                    end
                    nrch_pkg::STEP_PERP: begin
                        // hold r^2, take |cross| >> 14 as the offset
                        rad_next  = prod_reg[nrch_pkg::RADSQ_W-1:0];
                        perp_next = cross_abs[nrch_pkg::ACC_W-1:nrch_pkg::FRAC_SH];
                    end
                    nrch_pkg::STEP_P_P: begin
                        if (perp_reg > nrch_pkg::PROJ_W'(r_reg)) begin
                            // ray passes outside the circle: drop it
                            state_next = nrch_pkg::ST_FIN;
                        end else begin
                            prod_next = mul_p;
                        end
                    end
                    default: begin
                        rad_next    = rad_reg - prod_reg[nrch_pkg::RADSQ_W-1:0];
                        rem_next    = '0;
                        root_next   = '0;
                        sq_cnt_next = '0;
                        state_next  = nrch_pkg::ST_SQRT;
                    end
                endcase
            end

            nrch_pkg::ST_SQRT: begin
                rad_next    = rad_reg << 2;
                sq_cnt_next = sq_cnt_reg + nrch_pkg::SQ_CNT_W'(1);
                if (rem_sh >= trial) begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[nrch_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[nrch_pkg::ROOT_W-2:0], 1'b0};
                end
                if (sq_cnt_reg == nrch_pkg::SQ_CNT_W'(nrch_pkg::SQRT_STEPS - 1)) begin
                    state_next = nrch_pkg::ST_SUB;
                end
            end

            nrch_pkg::ST_SUB: begin
                // surface distance = floor(dot / 2^14) - chord
                surf_next = nrch_pkg::SURF_W'($signed(proj_reg[nrch_pkg::ACC_W-1:nrch_pkg::FRAC_SH]))
                          - $signed(nrch_pkg::SURF_W'(root_reg));
                state_next = nrch_pkg::ST_CMP;
            end

            nrch_pkg::ST_CMP: begin
                // strictly nearer only, so the earlier circle keeps a tie
                if (cand_hit) begin
                    best_dist_next = nrch_pkg::BEST_W'(surf_reg);
                    best_idx_next  = nrch_pkg::IDX_W'(item_count_reg);
                    hit_seen_next  = 1'b1;
                end
                state_next = nrch_pkg::ST_FIN;
            end

            nrch_pkg::ST_FIN: begin
                if (!last_reg) begin
                    item_count_next = cnt_wrap;
                    state_next      = nrch_pkg::ST_IDLE;
                end else if (out_free) begin
                    // emit the batch outcome and restart the batch
                    m_valid_next             = 1'b1;
                    m_data_next.found        = hit_seen_reg;
                    m_data_next.best_index   = hit_seen_reg ? best_idx_reg : '0;
                    m_data_next.best_distance = hit_seen_reg
                                              ? best_dist_reg[nrch_pkg::COORD_W-1:0] : '0;
                    best_dist_next  = nrch_pkg::BEST_W'(max_range_reg) + nrch_pkg::BEST_W'(1);
                    best_idx_next   = '0;
                    hit_seen_next   = 1'b0;
                    item_count_next = '0;
                    state_next      = nrch_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = nrch_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State register and control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= nrch_pkg::ST_IDLE;
            step_reg       <= '0;
            sq_cnt_reg     <= '0;
            item_count_reg <= '0;
            best_dist_reg  <= nrch_pkg::BEST_W'(nrch_pkg::MAX_RANGE_RST) + nrch_pkg::BEST_W'(1);
            best_idx_reg   <= '0;
            hit_seen_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            sq_cnt_reg     <= sq_cnt_next;
            item_count_reg <= item_count_next;
            best_dist_reg  <= best_dist_next;
            best_idx_reg   <= best_idx_next;
            hit_seen_reg   <= hit_seen_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Datapath registers: advance every cycle, no reset needed
    always_ff @(posedge aclk) begin
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        fx_reg     <= fx_next;
        fy_reg     <= fy_next;
        r_reg      <= r_next;
        last_reg   <= last_next;
        prod_reg   <= prod_next;
        proj_reg   <= proj_next;
        cross_reg  <= cross_next;
        perp_reg   <= perp_next;
        rad_reg    <= rad_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        surf_reg   <= surf_next;
        m_data_reg <= m_data_next;
    end

    // ------------------------------------------------------------------
    // Configuration port: one register, max_range, at byte address 0
    // ------------------------------------------------------------------
    logic cfg_hit;

    assign cfg_hit = (paddr[nrch_pkg::APB_ADDR_W-1:2] == nrch_pkg::REG_MAX_RANGE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_range_reg <= nrch_pkg::MAX_RANGE_RST;
        end else if (psel && penable && pwrite && cfg_hit) begin
            max_range_reg <= pwdata[nrch_pkg::RANGE_W-1:0];
        end
    end

    assign prdata = cfg_hit ? nrch_pkg::APB_DATA_W'(max_range_reg) : '0;
    assign pready = 1'b1;

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign s_ready = (state_reg == nrch_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `NRCH_ASSERT_SAME(a_word_from_last, $rose(m_valid_reg), $past(state_reg == nrch_pkg::ST_FIN) && $past(last_reg), "result word without a finished last circle")
    `NRCH_ASSERT_SAME(a_empty_result, m_valid_reg && !m_data_reg.found, (m_data_reg.best_index == '0) && (m_data_reg.best_distance == '0), "not-found word carries nonzero fields")
    `NRCH_ASSERT_NEXT(a_batch_restart, (state_reg == nrch_pkg::ST_FIN) && last_reg && out_free, !hit_seen_reg && (item_count_reg == '0) && (best_idx_reg == '0), "batch state not restarted after last circle")
    `NRCH_ASSERT_SAME(a_no_hit_no_idx, !hit_seen_reg, best_idx_reg == '0, "best index set without a hit")

endmodule

// ===== sim/nearest_ray_circle_hit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for nearest_ray_circle_hit: drives circle words and the APB register,
// predicts each batch outcome in a scoreboard class and checks every result word.
// Depends on nrch_pkg and nearest_ray_circle_hit only.
module nearest_ray_circle_hit_tb;

    localparam int unsigned CYCLE_LIMIT  = 600000;
    // Drain margin past the longest path a word takes through the block.
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned LONG_HOLD    = 600;
    localparam int unsigned PHASE_WORDS  = 275;
    localparam int unsigned NUM_PHASES   = 6;
    // Keep aimed geometry well inside the 24-bit coordinate space.
    localparam longint      FAR_REACH    = 2097152;
    localparam logic [nrch_pkg::APB_ADDR_W-1:0] RANGE_ADDR =
        nrch_pkg::APB_ADDR_W'(4 * nrch_pkg::REG_MAX_RANGE);

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_pattern_t;

    // Tracks the running nearest hit of the current batch and queues the
    // outcome each time a batch closes.
    class hit_scoreboard_t;
        logic [nrch_pkg::RANGE_W-1:0] range_limit;
        longint                       best_surface;
        logic [nrch_pkg::IDX_W-1:0]   best_pos;
        logic [nrch_pkg::IDX_W-1:0]   position;
        bit                           any_hit;
        nrch_pkg::nrch_out_t          pending_hits[$];
        int unsigned                  mismatches;

        function new();
            range_limit = nrch_pkg::MAX_RANGE_RST;
            mismatches  = 0;
            restart_batch();
        endfunction

        function void restart_batch();
            best_surface = longint'(range_limit) + 1;
            best_pos     = '0;
            position     = '0;
            any_hit      = 1'b0;
        endfunction

        // Floor square root, two bits of the radicand per step.
        function longint unsigned root_floor(longint unsigned v);
            longint unsigned rem;
            longint unsigned res;
            longint unsigned one;
            rem = v;
            res = 0;
            one = 64'h4000_0000_0000_0000;
            while (one > rem)
                one = one >> 2;
            while (one != 0) begin
                if (rem >= res + one) begin
                    rem = rem - (res + one);
                    res = (res >> 1) + one;
                end else begin
                    res = res >> 1;
                end
                one = one >> 2;
            end
            return res;
        endfunction

        function void note_circle(nrch_pkg::nrch_in_t w);
            longint              dx;
            longint              dy;
            longint              fx;
            longint              fy;
            longint              proj;
            longint              cr;
            longint              perp;
            longint              r;
            longint              surf;
            nrch_pkg::nrch_out_t res;
            dx = longint'($signed(w.center_x)) - longint'($signed(w.ray_origin_x));
            dy = longint'($signed(w.center_y)) - longint'($signed(w.ray_origin_y));
            fx = longint'($signed(w.ray_dir_x));
            fy = longint'($signed(w.ray_dir_y));
            r  = longint'(w.radius);
            if (w.eligible) begin
                proj = (dx * fx + dy * fy) >>> nrch_pkg::FRAC_SH;
                cr   = dx * fy - dy * fx;
                perp = (cr < 0 ? -cr : cr) >>> nrch_pkg::FRAC_SH;
                if (perp <= r) begin
                    surf = proj - longint'(root_floor(unsigned'(r * r - perp * perp)));
                    if (surf >= -r && surf <= longint'(range_limit) && surf < best_surface) begin
                        best_surface = surf;
                        best_pos     = position;
                        any_hit      = 1'b1;
                    end
                end
            end
            position = (position == nrch_pkg::IDX_W'(nrch_pkg::MAX_CIRCLES_DEF - 1))
                     ? '0 : position + 1'b1;
            if (w.last_item) begin
                res.found         = any_hit;
                res.best_index    = any_hit ? best_pos : '0;
                res.best_distance = any_hit ? best_surface[nrch_pkg::COORD_W-1:0] : '0;
                pending_hits.push_back(res);
                restart_batch();
            end
        endfunction

        function void check_result(nrch_pkg::nrch_out_t got);
            nrch_pkg::nrch_out_t want;
            if (pending_hits.size() == 0) begin
                $error("result word with no batch outstanding");
                mismatches++;
                return;
            end
            want = pending_hits.pop_front();
            if (got.found !== want.found) begin
                $error("found: expected %0d, actual %0d", want.found, got.found);
                mismatches++;
            end
            if (got.best_index !== want.best_index) begin
                $error("best_index: expected %0d, actual %0d", want.best_index, got.best_index);
                mismatches++;
            end
            if (got.best_distance !== want.best_distance) begin
                $error("best_distance: expected %0d, actual %0d",
                       $signed(want.best_distance), $signed(got.best_distance));
                mismatches++;
            end
        endfunction

        function void check_readback(logic [nrch_pkg::APB_DATA_W-1:0] rd);
            if (rd !== nrch_pkg::APB_DATA_W'(range_limit)) begin
                $error("max_range: expected %0d, actual %0d", range_limit, rd);
                mismatches++;
            end
        endfunction
    endclass

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    nrch_pkg::nrch_in_t              s_data;
    logic                            m_valid;
    logic                            m_ready;
    nrch_pkg::nrch_out_t             m_data;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [nrch_pkg::APB_ADDR_W-1:0] paddr;
    logic [nrch_pkg::APB_DATA_W-1:0] pwdata;
    logic [nrch_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    hit_scoreboard_t sb;
    int unsigned     burst_left = 0;
    int unsigned     cycle_count = 0;
    // Receiver state: a pattern that changes every so often, plus one long hold-off.
    bit              hold_request = 1'b0;
    int unsigned     hold_left = 0;
    rx_pattern_t     rx_pattern = RX_OPEN;
    int unsigned     pattern_left = 0;

    nearest_ray_circle_hit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Hard stop in case a handshake never completes.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $error("run exceeded %0d cycles", CYCLE_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // Sample both channels at the rising edge: log each accepted circle word
    // into the predictor and check each accepted result word.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_circle(s_data);
            if (m_valid && m_ready)
                sb.check_result(m_data);
        end
    end

    // Receiver: one assignment of m_ready per falling edge. A hold request
    // drops ready for a long stretch so the block backs up into s_ready.
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = LONG_HOLD - 1;
            m_ready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                rx_pattern   = rx_pattern_t'($urandom_range(0, 3));
                pattern_left = $urandom_range(20, 200);
            end
            pattern_left--;
            case (rx_pattern)
                RX_OPEN:   m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                default:   m_ready <= ~m_ready;
            endcase
        end
    end

    function automatic nrch_pkg::nrch_in_t circle(int ox, int oy, int fx, int fy,
                                                  int cx, int cy, int r, bit elig, bit last);
        nrch_pkg::nrch_in_t w;
        w.ray_origin_x = nrch_pkg::COORD_W'(ox);
        w.ray_origin_y = nrch_pkg::COORD_W'(oy);
        w.ray_dir_x    = nrch_pkg::DIR_W'(fx);
        w.ray_dir_y    = nrch_pkg::DIR_W'(fy);
        w.center_x     = nrch_pkg::COORD_W'(cx);
        w.center_y     = nrch_pkg::COORD_W'(cy);
        w.radius       = nrch_pkg::RAD_W'(r);
        w.eligible     = elig;
        w.last_item    = last;
        return w;
    endfunction

    // Ray from the origin along +x; the circle's near surface sits at s.
    function automatic nrch_pkg::nrch_in_t on_axis(int s, int r, bit elig, bit last);
        return circle(0, 0, 16384, 0, s + r, 0, r, elig, last);
    endfunction

    // Place a circle on the given ray so its surface lands near the range
    // edge, inside it, or around the origin; the side offset sometimes
    // exceeds the radius so the ray misses.
    function automatic nrch_pkg::nrch_in_t aimed_circle(longint ox, longint oy,
                                                        longint fx, longint fy);
        nrch_pkg::nrch_in_t w;
        longint             r;
        longint             s;
        longint             lim;
        longint             span;
        longint             off;
        longint             t;
        if ($urandom_range(0, 7) == 0)
            r = longint'($urandom_range(0, 1048575));
        else
            r = longint'($urandom_range(1, 8192));
        lim = (longint'(sb.range_limit) > FAR_REACH) ? FAR_REACH : longint'(sb.range_limit);
        case ($urandom_range(0, 3))
            0:       s = longint'($urandom_range(0, 32'(r))) - r;
            1:       s = lim - 4 + longint'($urandom_range(0, 8));
            default: s = longint'($urandom_range(0, 32'(lim)));
        endcase
        span = ($urandom_range(0, 3) != 0) ? r : r + r / 4 + 2;
        off  = longint'($urandom_range(0, 32'(2 * span))) - span;
        t    = s + r;
        w.ray_origin_x = nrch_pkg::COORD_W'(ox);
        w.ray_origin_y = nrch_pkg::COORD_W'(oy);
        w.ray_dir_x    = nrch_pkg::DIR_W'(fx);
        w.ray_dir_y    = nrch_pkg::DIR_W'(fy);
        w.center_x     = nrch_pkg::COORD_W'(ox + ((t * fx) >>> nrch_pkg::FRAC_SH)
                                               - ((off * fy) >>> nrch_pkg::FRAC_SH));
        w.center_y     = nrch_pkg::COORD_W'(oy + ((t * fy) >>> nrch_pkg::FRAC_SH)
                                               + ((off * fx) >>> nrch_pkg::FRAC_SH));
        w.radius       = nrch_pkg::RAD_W'(r);
        w.eligible     = 1'b1;
        w.last_item    = 1'b0;
        return w;
    endfunction

    // Random coordinates, radius and eligibility; direction kept in range; not last.
    function automatic nrch_pkg::nrch_in_t noise_circle();
        nrch_pkg::nrch_in_t w;
        w.ray_origin_x = nrch_pkg::COORD_W'($urandom);
        w.ray_origin_y = nrch_pkg::COORD_W'($urandom);
        w.ray_dir_x    = nrch_pkg::DIR_W'(int'($urandom_range(0, 32768)) - 16384);
        w.ray_dir_y    = nrch_pkg::DIR_W'(int'($urandom_range(0, 32768)) - 16384);
        w.center_x     = nrch_pkg::COORD_W'($urandom);
        w.center_y     = nrch_pkg::COORD_W'($urandom);
        w.radius       = nrch_pkg::RAD_W'($urandom);
        w.eligible     = 1'($urandom_range(0, 1));
        w.last_item    = 1'b0;
        return w;
    endfunction

    // Offer one word, entered and left at a falling edge. Between bursts,
    // drop valid for a random gap; within a burst valid stays high.
    task automatic send_word(nrch_pkg::nrch_in_t w);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_data  <= w;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        burst_left--;
    endtask

    // Drop valid, let every expected result drain, then give the last
    // resultless word time to clear the pipeline.
    task automatic wait_quiet();
        s_valid <= 1'b0;
        while (sb.pending_hits.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Write max_range, then read it straight back in the same select.
    task automatic write_range(logic [nrch_pkg::RANGE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RANGE_ADDR;
        pwdata  <= nrch_pkg::APB_DATA_W'(value);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.range_limit = value;
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.check_readback(prdata);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // One batch on a shared ray: mostly aimed circles, some repeats of the
    // previous circle to force ties, some ineligible, some noise.
    task automatic run_batch(int unsigned len);
        longint             ox;
        longint             oy;
        longint             fx;
        longint             fy;
        real                ang;
        nrch_pkg::nrch_in_t w;
        nrch_pkg::nrch_in_t prev;
        bit                 have_prev;
        int unsigned        pick;
        int unsigned        i;
        ox  = longint'($urandom_range(0, 4194304)) - 2097152;
        oy  = longint'($urandom_range(0, 4194304)) - 2097152;
        ang = real'($urandom_range(0, 35999)) * 3.14159265358979 / 18000.0;
        fx  = longint'($rtoi($cos(ang) * 16384.0));
        fy  = longint'($rtoi($sin(ang) * 16384.0));
        have_prev = 1'b0;
        for (i = 0; i < len; i++) begin
            pick = $urandom_range(0, 9);
            if (pick == 6 && have_prev) begin
                w = prev;
            end else if (pick >= 8) begin
                w = noise_circle();
            end else begin
                w = aimed_circle(ox, oy, fx, fy);
                w.eligible = (pick != 7);
                prev = w;
                have_prev = 1'b1;
            end
            w.last_item = (i == len - 1);
            send_word(w);
        end
    endtask

    initial begin
        int unsigned                  phase_words;
        int unsigned                  len;
        int unsigned                  p;
        logic [nrch_pkg::RANGE_W-1:0] phase_range [NUM_PHASES];

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        m_ready = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        sb = new();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed batches under the reset range of 32000.
        // Batch of one ineligible circle: nothing found.
        send_word(circle(0, 0, 16384, 0, 25600, 0, 2560, 1'b0, 1'b1));
        // Straight-on hit.
        send_word(on_axis(23040, 2560, 1'b1, 1'b1));
        // Ineligible copy first, then a tie: the earlier eligible copy wins.
        send_word(on_axis(23040, 2560, 1'b0, 1'b0));
        send_word(on_axis(23040, 2560, 1'b1, 1'b0));
        send_word(on_axis(23040, 2560, 1'b1, 1'b0));
        send_word(on_axis(27000, 2560, 1'b1, 1'b1));
        // Tangent, offset one past the radius, origin inside, circle behind.
        send_word(circle(0, 0, 0, 16384, 1280, 12800, 1280, 1'b1, 1'b0));
        send_word(circle(0, 0, 0, 16384, 1281, 6400, 1280, 1'b1, 1'b0));
        send_word(circle(0, 0, 0, 16384, 0, 256, 2560, 1'b1, 1'b0));
        send_word(circle(0, 0, 0, 16384, 0, -25600, 2560, 1'b1, 1'b1));
        // One past the range edge, then exactly on it.
        send_word(on_axis(32001, 256, 1'b1, 1'b0));
        send_word(on_axis(32000, 256, 1'b1, 1'b1));
        // Extreme coordinates and radius, then a non-unit diagonal direction.
        send_word(circle(-8388608, -8388608, 16384, -16384, 8388607, 8388607,
                         1048575, 1'b1, 1'b0));
        send_word(circle(8388607, 8388607, -16384, -16384, -8388608, -8388608,
                         1048575, 1'b1, 1'b0));
        send_word(circle(0, 0, 16384, 16384, 12800, 12800, 2560, 1'b1, 1'b1));
        // Range shrinks mid-batch: the later test uses the new range while
        // the nearest-so-far keeps the batch's opening bound.
        send_word(on_axis(30000, 2560, 1'b1, 1'b0));
        wait_quiet();
        write_range(nrch_pkg::RANGE_W'(20000));
        send_word(on_axis(25000, 2560, 1'b1, 1'b0));
        send_word(on_axis(10000, 2560, 1'b1, 1'b1));
        // New batch bound comes from the new range: a tie exactly on it.
        send_word(on_axis(20000, 1, 1'b1, 1'b0));
        send_word(on_axis(20000, 1, 1'b1, 1'b1));

        // Random phases, each under its own range setting, extremes included.
        phase_range[0] = '0;
        phase_range[1] = {nrch_pkg::RANGE_W{1'b1}};
        phase_range[2] = nrch_pkg::RANGE_W'($urandom_range(0, 8388607));
        phase_range[3] = nrch_pkg::MAX_RANGE_RST;
        phase_range[4] = nrch_pkg::RANGE_W'($urandom_range(256, 4096));
        phase_range[5] = nrch_pkg::RANGE_W'($urandom_range(0, 8388607));
        for (p = 0; p < NUM_PHASES; p++) begin
            wait_quiet();
            write_range(phase_range[p]);
            // Hold off the receiver once while words keep coming.
            if (p == 2)
                hold_request = 1'b1;
            phase_words = 0;
            while (phase_words < PHASE_WORDS) begin
                if (p == 3 && phase_words == 0)
                    len = 70;   // longer than the index space: position wraps
                else if ($urandom_range(0, 19) < 17)
                    len = $urandom_range(1, 8);
                else
                    len = $urandom_range(9, 40);
                run_batch(len);
                phase_words += len;
            end
        end

        wait_quiet();
        if (sb.mismatches == 0 && sb.pending_hits.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
